// ===== sv/clsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clsm_pkg: shared types and constants of the clip launch controller
// Item structs, state and code enums, unit command and status structs.
// ----------------------------------------------------------------------------
package clsm_pkg;

  localparam int POS_W           = 32;
  localparam int START_W         = 40;
  localparam int QUANT_W         = 24;
  localparam int FRAME_W         = 14;
  localparam int MAX_PERIOD      = 8192;
  localparam int FADE_MIN_FRAMES = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int REM_CNT_W       = $clog2(START_W);

  typedef enum logic [2:0] {
    ST_STOPPED     = 3'd0,
    ST_RUNNING     = 3'd1,
    ST_WAIT_START  = 3'd2,
    ST_WAIT_STOP   = 3'd3,
    ST_WAIT_RETRIG = 3'd4,
    ST_STOPPING    = 3'd5
  } slot_state_e;

  typedef enum logic [1:0] {
    RK_NONE  = 2'd0,
    RK_ALL   = 2'd1,
    RK_START = 2'd2,
    RK_END   = 2'd3
  } run_kind_e;

  typedef enum logic [2:0] {
    CMD_BANG   = 3'd0,
    CMD_UNBANG = 3'd1,
    CMD_START  = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_PERIOD = 3'd4
  } command_e;

  typedef enum logic [1:0] {
    STYLE_ONE_SHOT = 2'd0,
    STYLE_GATE     = 2'd1,
    STYLE_TOGGLE   = 2'd2,
    STYLE_REPEAT   = 2'd3
  } style_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAUNCH_STYLE    = 3'd0,
    CFG_QUANTUM_SAMPLES = 3'd1,
    CFG_CLIP_START      = 3'd2,
    CFG_USABLE_LENGTH   = 3'd3,
    CFG_LEGATO_OFFSET   = 3'd4,
    CFG_FOLLOW_SELF     = 3'd5
  } cfg_index_e;

  typedef enum logic [2:0] {
    SEQ_IDLE = 3'd0,
    SEQ_REM  = 3'd1,
    SEQ_PLAN = 3'd2,
    SEQ_WALK = 3'd3,
    SEQ_DONE = 3'd4
  } seq_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [START_W-1:0] period_start_sample;
    logic [FRAME_W-1:0] period_frames;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         slot_state_out;
    logic [1:0]         run_kind;
    logic [FRAME_W-1:0] audio_offset;
    logic [FRAME_W-1:0] play_frames;
    logic [FRAME_W-1:0] silence_frames;
    logic [POS_W-1:0]   read_start;
    logic [POS_W-1:0]   read_end;
    logic [FRAME_W-1:0] wrap_count;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [START_W-1:0] dividend;
    logic [QUANT_W-1:0] divisor;
  } rem_cmd_t;

  typedef struct packed {
    logic               busy;
    logic [QUANT_W-1:0] rem;
  } rem_sts_t;

  typedef struct packed {
    logic               start;
    logic [POS_W-1:0]   rp;
    logic [FRAME_W-1:0] frames;
    logic [POS_W-1:0]   last;
    logic [POS_W-1:0]   again;
    logic               loop_ok;
  } walk_cmd_t;

  typedef struct packed {
    logic               busy;
    logic [POS_W-1:0]   rp;
    logic [FRAME_W-1:0] played;
    logic [FRAME_W-1:0] silence;
    logic [FRAME_W-1:0] wraps;
    logic               ended;
  } walk_sts_t;

endpackage
`default_nettype wire

// ===== sv/clip_launch_state_machine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clip_launch_state_machine: launch controller of one playback slot
// Event handling, quantized launch decision and read pointer bookkeeping.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall_o is high from acceptance until the
// result has been placed in the output register. A bang, unbang, start or
// stop request, an unknown command, or a period seen while stopped goes
// straight to the done state. Any other period goes through a plan state,
// which ends the item if the launch decision plays nothing and else starts
// the pointer walker; while waiting for a launch with a nonzero quantum, the
// bit-serial remainder unit first finds the distance to the next quantum
// boundary, one step per bit of the period start. The walker crosses one
// clip segment per clip end reached, plus the final partial segment. A
// stalled output register holds the result in the done state until it is
// free. The next item may be taken while the previous result still waits
// at the output.
// ----------------------------------------------------------------------------
module clip_launch_state_machine (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [clsm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [clsm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output      logic                               in_stall_o,
  input  wire clsm_pkg::in_item_t                 in_item_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      clsm_pkg::out_item_t                out_item_o
);
  import clsm_pkg::*;

  style_e             style_q;
  logic [QUANT_W-1:0] quantum_q;
  logic [POS_W-1:0]   clip_start_q;
  logic [POS_W-1:0]   usable_len_q;
  logic [POS_W-1:0]   legato_q;
  logic               follow_q;

  seq_e               seq_q, seq_d;
  slot_state_e        slot_q, slot_d;
  logic [POS_W-1:0]   rp_q, rp_d;
  logic [FRAME_W-1:0] n_q, n_d;
  logic [FRAME_W-1:0] dist_q, dist_d;
  logic               hit_q, hit_d;
  run_kind_e          kind_q, kind_d;
  logic [FRAME_W-1:0] dest_q, dest_d;
  logic [FRAME_W-1:0] frames_q, frames_d;
  logic [POS_W-1:0]   rstart_q, rstart_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  rem_cmd_t  rem_cmd;
  rem_sts_t  rem_sts;
  walk_cmd_t walk_cmd;
  walk_sts_t walk_sts;

  logic               accept;
  logic               out_free;
  logic               is_period;
  logic [FRAME_W-1:0] n_sat;
  logic [POS_W-1:0]   last_pos;
  logic [POS_W-1:0]   again_pos;
  logic               loop_ok;
  logic [QUANT_W-1:0] dist_full;
  logic               dist_hit;
  slot_state_e        walk_slot;

  run_kind_e          plan_kind;
  slot_state_e        plan_slot;
  logic               plan_retrig;
  logic [FRAME_W-1:0] plan_frames;
  logic [FRAME_W-1:0] plan_dest;
  logic [POS_W-1:0]   plan_rp;

  function automatic slot_state_e event_next(slot_state_e s, logic [2:0] cmd, style_e st);
    slot_state_e r;
    r = s;
    unique case (cmd)
      CMD_BANG: begin
        if (s == ST_RUNNING) begin
          r = (st == STYLE_ONE_SHOT) ? ST_WAIT_RETRIG : ST_WAIT_STOP;
        end else if (s == ST_STOPPED) begin
          r = ST_WAIT_START;
        end
      end
      CMD_UNBANG: begin
        if (st == STYLE_GATE || st == STYLE_REPEAT) begin
          r = (s == ST_RUNNING) ? ST_WAIT_STOP : ST_STOPPED;
        end
      end
      CMD_START: begin
        if (s != ST_RUNNING) begin
          r = ST_WAIT_START;
        end
      end
      CMD_STOP: begin
        if (s != ST_STOPPED) begin
          r = ST_WAIT_STOP;
        end
      end
      default: r = s;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      style_q      <= STYLE_TOGGLE;
      quantum_q    <= '0;
      clip_start_q <= '0;
      usable_len_q <= '0;
      legato_q     <= '0;
      follow_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LAUNCH_STYLE:    style_q      <= style_e'(cfg_wdata_i[1:0]);
        CFG_QUANTUM_SAMPLES: quantum_q    <= cfg_wdata_i[QUANT_W-1:0];
        CFG_CLIP_START:      clip_start_q <= cfg_wdata_i[POS_W-1:0];
        CFG_USABLE_LENGTH:   usable_len_q <= cfg_wdata_i[POS_W-1:0];
        CFG_LEGATO_OFFSET:   legato_q     <= cfg_wdata_i[POS_W-1:0];
        CFG_FOLLOW_SELF:     follow_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign accept    = in_valid_i && (seq_q == SEQ_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign is_period = (in_item_i.command == CMD_PERIOD);
  assign n_sat     = (in_item_i.period_frames > FRAME_W'(MAX_PERIOD)) ?
                     FRAME_W'(MAX_PERIOD) : in_item_i.period_frames;
  assign last_pos  = clip_start_q + usable_len_q;
  assign again_pos = clip_start_q + legato_q;
  assign loop_ok   = (style_q == STYLE_REPEAT || follow_q) && (again_pos < last_pos);
  assign dist_full = (rem_sts.rem == '0) ? '0 : quantum_q - rem_sts.rem;
  assign dist_hit  = dist_full < {{(QUANT_W-FRAME_W){1'b0}}, n_q};

  always_comb begin
    plan_kind   = RK_NONE;
    plan_slot   = slot_q;
    plan_retrig = 1'b0;
    plan_frames = n_q;
    plan_dest   = '0;
    unique case (slot_q)
      ST_RUNNING, ST_STOPPING: plan_kind = RK_ALL;
      ST_WAIT_STOP: begin
        if (hit_q) begin
          plan_kind   = RK_END;
          plan_slot   = ST_STOPPING;
          plan_frames = dist_q;
        end else begin
          plan_kind = RK_ALL;
        end
      end
      ST_WAIT_START: begin
        if (hit_q) begin
          plan_kind   = RK_START;
          plan_slot   = ST_RUNNING;
          plan_retrig = 1'b1;
          plan_dest   = dist_q;
          plan_frames = n_q - dist_q;
        end
      end
      ST_WAIT_RETRIG: begin
        plan_kind = RK_ALL;
        if (hit_q) begin
          plan_slot   = ST_RUNNING;
          plan_retrig = 1'b1;
        end
      end
      default: plan_kind = RK_NONE;
    endcase
    plan_rp = plan_retrig ? again_pos : rp_q;
  end

  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          if (!is_period || slot_q == ST_STOPPED) begin
            seq_d = SEQ_DONE;
          end else if (slot_q == ST_RUNNING || slot_q == ST_STOPPING || quantum_q == '0) begin
            seq_d = SEQ_PLAN;
          end else begin
            seq_d = SEQ_REM;
          end
        end
      end
      SEQ_REM:  if (!rem_sts.busy) seq_d = SEQ_PLAN;
      SEQ_PLAN: seq_d = (plan_kind == RK_NONE) ? SEQ_DONE : SEQ_WALK;
      SEQ_WALK: if (!walk_sts.busy) seq_d = SEQ_DONE;
      SEQ_DONE: if (out_free) seq_d = SEQ_IDLE;
      default:  seq_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    slot_d      = slot_q;
    rp_d        = rp_q;
    n_d         = n_q;
    dist_d      = dist_q;
    hit_d       = hit_q;
    kind_d      = kind_q;
    dest_d      = dest_q;
    frames_d    = frames_q;
    rstart_d    = rstart_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    walk_slot   = walk_sts.ended ? ST_STOPPED : slot_q;

    rem_cmd.start    = 1'b0;
    rem_cmd.dividend = in_item_i.period_start_sample;
    rem_cmd.divisor  = quantum_q;

    walk_cmd.start   = 1'b0;
    walk_cmd.rp      = plan_rp;
    walk_cmd.frames  = plan_frames;
    walk_cmd.last    = last_pos;
    walk_cmd.again   = again_pos;
    walk_cmd.loop_ok = loop_ok;

    unique case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          kind_d   = RK_NONE;
          dest_d   = '0;
          frames_d = '0;
          rstart_d = rp_q;
          n_d      = n_sat;
          dist_d   = '0;
          hit_d    = (n_sat != '0);
          if (!is_period) begin
            slot_d = event_next(slot_q, in_item_i.command, style_q);
          end else if (slot_q != ST_STOPPED && slot_q != ST_RUNNING &&
                       slot_q != ST_STOPPING && quantum_q != '0) begin
            rem_cmd.start = 1'b1;
          end
        end
      end
      SEQ_REM: begin
        if (!rem_sts.busy) begin
          dist_d = dist_full[FRAME_W-1:0];
          hit_d  = dist_hit;
        end
      end
      SEQ_PLAN: begin
        kind_d         = plan_kind;
        slot_d         = plan_slot;
        rp_d           = plan_rp;
        rstart_d       = plan_rp;
        dest_d         = plan_dest;
        frames_d       = plan_frames;
        walk_cmd.start = (plan_kind != RK_NONE);
      end
      SEQ_WALK: begin
        if (!walk_sts.busy) begin
          rp_d = walk_sts.rp;
          if (walk_slot == ST_STOPPING && frames_q >= FRAME_W'(FADE_MIN_FRAMES)) begin
            slot_d = ST_STOPPED;
          end else begin
            slot_d = walk_slot;
          end
        end
      end
      SEQ_DONE: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.slot_state_out = slot_q;
          out_d.run_kind       = kind_q;
          out_d.audio_offset   = dest_q;
          out_d.play_frames    = (kind_q == RK_NONE) ? '0 : walk_sts.played;
          out_d.silence_frames = (kind_q == RK_NONE) ? '0 : walk_sts.silence;
          out_d.read_start     = rstart_q;
          out_d.read_end       = rp_q;
          out_d.wrap_count     = (kind_q == RK_NONE) ? '0 : walk_sts.wraps;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      slot_q      <= ST_STOPPED;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      slot_q      <= slot_d;
      rp_q        <= rp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    dist_q   <= dist_d;
    hit_q    <= hit_d;
    kind_q   <= kind_d;
    dest_q   <= dest_d;
    frames_q <= frames_d;
    rstart_q <= rstart_d;
    out_q    <= out_d;
  end

  clsm_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (rem_cmd),
    .sts_o  (rem_sts)
  );

  clsm_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (walk_cmd),
    .sts_o  (walk_sts)
  );

  assign in_stall_o  = (seq_q != SEQ_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (seq_q != SEQ_IDLE))
    else $error("item accepted but sequencer stayed idle");

  a_walk_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_sts.busy |-> (seq_q == SEQ_WALK))
    else $error("pointer walker busy outside walk phase");

  a_none_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.run_kind == RK_NONE) |->
    (out_item_o.play_frames == '0 && out_item_o.wrap_count == '0 &&
     out_item_o.read_start == out_item_o.read_end))
    else $error("idle result moved the read pointer");

  a_end_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.run_kind == RK_END) |->
    (out_item_o.slot_state_out == ST_STOPPING || out_item_o.slot_state_out == ST_STOPPED))
    else $error("end-inside result left slot in a wrong state");
`endif

endmodule
`default_nettype wire

// ===== sv/clsm_rem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clsm_rem: iterative remainder unit
// Restoring remainder of the period start by the quantum, one bit a cycle.
// ----------------------------------------------------------------------------
module clsm_rem (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire clsm_pkg::rem_cmd_t cmd_i,
  output      clsm_pkg::rem_sts_t sts_o
);
  import clsm_pkg::*;

  logic                 busy_q, busy_d;
  logic [REM_CNT_W-1:0] cnt_q, cnt_d;
  logic [START_W-1:0]   div_q, div_d;
  logic [QUANT_W-1:0]   dsr_q, dsr_d;
  logic [QUANT_W-1:0]   rem_q, rem_d;
  logic [QUANT_W:0]     shifted;
  logic [QUANT_W+1:0]   diff;

  assign shifted = {rem_q, div_q[START_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    div_d  = div_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = cmd_i.dividend;
      dsr_d  = cmd_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      div_d = {div_q[START_W-2:0], 1'b0};
      rem_d = diff[QUANT_W+1] ? shifted[QUANT_W-1:0] : diff[QUANT_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == REM_CNT_W'(START_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.rem  = rem_q;

endmodule
`default_nettype wire

// ===== sv/clsm_walk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clsm_walk: read pointer walker
// Advances the read pointer through the clip, one clip segment a cycle,
// with wrap to the retrigger point or end-stop with silence.
// ----------------------------------------------------------------------------
module clsm_walk (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire clsm_pkg::walk_cmd_t cmd_i,
  output      clsm_pkg::walk_sts_t sts_o
);
  import clsm_pkg::*;

  logic               busy_q, busy_d;
  logic [POS_W-1:0]   rp_q, rp_d;
  logic [FRAME_W-1:0] left_q, left_d;
  logic [FRAME_W-1:0] played_q, played_d;
  logic [FRAME_W-1:0] silence_q, silence_d;
  logic [FRAME_W-1:0] wraps_q, wraps_d;
  logic               ended_q, ended_d;
  logic [POS_W-1:0]   last_q, last_d;
  logic [POS_W-1:0]   again_q, again_d;
  logic               loop_ok_q, loop_ok_d;

  logic [POS_W:0]     avail_ext;
  logic [POS_W-1:0]   avail;
  logic [FRAME_W-1:0] take;
  logic [POS_W-1:0]   rp_sum;
  logic [FRAME_W-1:0] left_rem;
  logic               at_end;

  always_comb begin
    avail_ext = {1'b0, last_q} - {1'b0, rp_q};
    avail     = (!avail_ext[POS_W] && (avail_ext[POS_W-1:0] != '0)) ?
                avail_ext[POS_W-1:0] : '0;
    take      = ({{(POS_W-FRAME_W){1'b0}}, left_q} < avail) ? left_q : avail[FRAME_W-1:0];
    rp_sum    = rp_q + {{(POS_W-FRAME_W){1'b0}}, take};
    left_rem  = left_q - take;
    at_end    = (rp_sum >= last_q);
  end

  always_comb begin
    busy_d    = busy_q;
    rp_d      = rp_q;
    left_d    = left_q;
    played_d  = played_q;
    silence_d = silence_q;
    wraps_d   = wraps_q;
    ended_d   = ended_q;
    last_d    = last_q;
    again_d   = again_q;
    loop_ok_d = loop_ok_q;
    if (cmd_i.start) begin
      busy_d    = 1'b1;
      rp_d      = cmd_i.rp;
      left_d    = cmd_i.frames;
      played_d  = '0;
      silence_d = '0;
      wraps_d   = '0;
      ended_d   = 1'b0;
      last_d    = cmd_i.last;
      again_d   = cmd_i.again;
      loop_ok_d = cmd_i.loop_ok;
    end else if (busy_q) begin
      if (left_q == '0) begin
        busy_d = 1'b0;
      end else begin
        played_d = played_q + take;
        if (!at_end) begin
          rp_d   = rp_sum;
          left_d = left_rem;
        end else if (loop_ok_q) begin
          rp_d    = again_q;
          left_d  = left_rem;
          wraps_d = wraps_q + 1'b1;
        end else begin
          rp_d      = rp_sum;
          left_d    = '0;
          silence_d = left_rem;
          ended_d   = 1'b1;
          busy_d    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q      <= rp_d;
    left_q    <= left_d;
    played_q  <= played_d;
    silence_q <= silence_d;
    wraps_q   <= wraps_d;
    ended_q   <= ended_d;
    last_q    <= last_d;
    again_q   <= again_d;
    loop_ok_q <= loop_ok_d;
  end

  assign sts_o.busy    = busy_q;
  assign sts_o.rp      = rp_q;
  assign sts_o.played  = played_q;
  assign sts_o.silence = silence_q;
  assign sts_o.wraps   = wraps_q;
  assign sts_o.ended   = ended_q;

endmodule
`default_nettype wire
